>>> rtl/core/arpt_pkg.sv
package arpt_pkg;

  localparam int unsigned SLOT_W = 4;

  localparam logic [1:0] OP_MATCH  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] area_id;
    logic [31:0] address;
    logic [31:0] netmask;
    logic        suppress;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       hit_address;
    logic [31:0]       hit_mask;
    logic              hit_suppress;
    logic              recompute;
    logic              any_present;
  } out_t;

  typedef struct packed {
    logic [31:0] area;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic        suppress;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic hit;
    logic last_eval;
  } ctrl_sts_t;

endpackage

>>> rtl/core/area_range_prefix_table_core.sv
// Table of up to ENTRIES area summary ranges with match, add and remove
// commands. A command transfers when start is high while busy is low; its
// single result appears on res_o for exactly one cycle with res_valid_o
// high and must be taken then, as the receiver cannot stall it. A command
// scans the table one entry per cycle through a registered memory read and
// stops early when an entry hits; an unused opcode or a match on an empty
// table skips the scan. Busy falls in the cycle that presents the result,
// so the next command can transfer at the edge that takes it.
module area_range_prefix_table_core
  import arpt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  cmd_i,
  output logic res_valid_o,
  output out_t res_o
);

  ctrl_cmd_t ctrl;
  ctrl_sts_t sts;

  arpt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (ctrl)
  );

  arpt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .ctrl_i      (ctrl),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

>>> rtl/core/arpt_ctrl.sv
module arpt_ctrl
  import arpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = sts_i.skip ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.last_eval) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_FINISH: begin
        cmd_o.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/core/arpt_datapath.sv
module arpt_datapath
  import arpt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_t       cmd_i,
  input  ctrl_cmd_t ctrl_i,
  output ctrl_sts_t sts_o,
  output logic      res_valid_o,
  output out_t      res_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  in_t                 op_q;
  entry_t              mem_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [IW-1:0]       addr_q;
  logic                issue_done_q;
  logic                rd_vld_q;
  logic [IW-1:0]       rd_idx_q;
  logic                rd_ev_q;
  entry_t              rd_ent_q;
  logic                found_q;
  logic [IW-1:0]       found_idx_q;
  entry_t              found_ent_q;
  logic                free_q;
  logic [IW-1:0]       free_idx_q;
  logic                issue;
  logic                area_eq;
  logic                exact;
  logic                mhit;
  logic                hit;
  logic                wr_en;
  logic [IW-1:0]       wr_idx;
  out_t                res_d;

  assign issue = ctrl_i.scan && !issue_done_q;

  // entry compare at the evaluation stage
  assign area_eq = rd_ev_q && (rd_ent_q.area == op_q.area_id);
  assign exact   = area_eq && (rd_ent_q.prefix == op_q.address)
                   && (rd_ent_q.mask == op_q.netmask);
  assign mhit    = area_eq && (rd_ent_q.mask <= op_q.netmask)
                   && (((rd_ent_q.prefix ^ op_q.address) & rd_ent_q.mask) == 32'd0);
  assign hit     = ctrl_i.scan && rd_vld_q && ((op_q.opcode == OP_MATCH) ? mhit : exact);

  assign sts_o.hit       = hit;
  assign sts_o.last_eval = ctrl_i.scan && rd_vld_q && (rd_idx_q == LAST_IDX);
  assign sts_o.skip      = !((cmd_i.opcode == OP_ADD) || (cmd_i.opcode == OP_REMOVE)
                             || ((cmd_i.opcode == OP_MATCH) && (|valid_q)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_q       <= 1'b0;
    end else if (ctrl_i.load) begin
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_q       <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        addr_q       <= addr_q + 1'b1;
        issue_done_q <= (addr_q == LAST_IDX);
      end
      if (hit && !found_q) begin
        found_q <= 1'b1;
      end
      if (ctrl_i.scan && rd_vld_q && !rd_ev_q && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= addr_q;
      rd_ev_q  <= valid_q[addr_q];
      rd_ent_q <= mem_q[addr_q];
    end
    if (hit && !found_q) begin
      found_idx_q <= rd_idx_q;
      found_ent_q <= rd_ent_q;
    end
    if (ctrl_i.scan && rd_vld_q && !rd_ev_q && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  // commit of table update and result
  always_comb begin
    valid_d = valid_q;
    wr_en   = 1'b0;
    wr_idx  = found_idx_q;
    res_d   = '0;
    res_d.status = ST_MISS;
    case (op_q.opcode)
      OP_MATCH: begin
        if (found_q) begin
          res_d.status       = ST_OK;
          res_d.slot         = SLOT_W'(found_idx_q);
          res_d.hit_address  = found_ent_q.prefix;
          res_d.hit_mask     = found_ent_q.mask;
          res_d.hit_suppress = found_ent_q.suppress;
        end
      end
      OP_ADD: begin
        if (found_q) begin
          wr_en           = 1'b1;
          res_d.status    = ST_OK;
          res_d.slot      = SLOT_W'(found_idx_q);
          res_d.recompute = found_ent_q.suppress != op_q.suppress;
        end else if (free_q) begin
          wr_en           = 1'b1;
          wr_idx          = free_idx_q;
          valid_d[free_idx_q] = 1'b1;
          res_d.status    = ST_OK;
          res_d.slot      = SLOT_W'(free_idx_q);
          res_d.recompute = 1'b1;
        end else begin
          res_d.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (found_q) begin
          valid_d[found_idx_q] = 1'b0;
          res_d.status    = ST_OK;
          res_d.slot      = SLOT_W'(found_idx_q);
          res_d.recompute = 1'b1;
        end
      end
      default: begin
        res_d.status = ST_MISS;
      end
    endcase
    res_d.any_present = |valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && wr_en) begin
      mem_q[wr_idx] <= '{area: op_q.area_id, prefix: op_q.address,
                         mask: op_q.netmask, suppress: op_q.suppress};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= ctrl_i.commit;
      if (ctrl_i.commit) begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      res_o <= res_d;
    end
  end

endmodule
